// ===== rtl/core/emp_pkg.sv =====
package emp_pkg;

	localparam int COORD_W        = 24;
	localparam int DIFF_W         = COORD_W + 1;
	localparam int DIST_W         = 25;
	localparam int ROOT_STEPS     = DIST_W;
	localparam int RAD_W          = 2 * ROOT_STEPS;
	localparam int REM_W          = DIST_W + 2;
	localparam int TOTAL_W        = 31;
	localparam int COUNT_W        = 7;
	localparam int MAX_POINTS_DEF = 64;

	localparam logic [DIST_W-1:0]  DIST_INF  = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_PICK_RD,
		ST_PICK_WT,
		ST_SCAN_RD,
		ST_SCAN_WT,
		ST_DIST,
		ST_UPD,
		ST_NEXT,
		ST_OUT
	} emp_state_t;

	typedef enum logic [2:0] {
		DS_IDLE,
		DS_SQX,
		DS_SQY,
		DS_SUM,
		DS_ROOT
	} dist_state_t;

	typedef struct packed {
		logic start;
	} dist_req_t;

	typedef struct packed {
		logic done;
	} dist_rsp_t;

endpackage

// ===== rtl/core/emp_ram.sv =====
module emp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/emp_dist.sv =====
// Edge length unit: one shared 24x24 multiplier for both squares, then a
// restoring square root, two radicand bits per cycle.
module emp_dist
	import emp_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dist_req_t                 req,
	input  logic signed [DIFF_W-1:0]  dx,
	input  logic signed [DIFF_W-1:0]  dy,
	output dist_rsp_t                 rsp,
	output logic [DIST_W-1:0]         dist_len
);

	localparam int CNT_W = $clog2(ROOT_STEPS + 1);

	dist_state_t state_q, state_d;
	logic [COORD_W-1:0]   ax_q, ay_q;
	logic [2*COORD_W-1:0] prod_q;
	logic [RAD_W-1:0]     rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [DIST_W-1:0]    root_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;

	logic [COORD_W-1:0]   mul_in;
	logic [REM_W+1:0]     shifted;
	logic [REM_W+1:0]     trial;
	logic [DIFF_W-1:0]    abs_x, abs_y;

	assign abs_x   = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
	assign abs_y   = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
	assign mul_in  = (state_q == DS_SQX) ? ax_q : ay_q;
	assign shifted = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial   = (REM_W+2)'({root_q, 2'b01});

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DS_IDLE: if (req.start) state_d = DS_SQX;
			DS_SQX:  state_d = DS_SQY;
			DS_SQY:  state_d = DS_SUM;
			DS_SUM:  state_d = DS_ROOT;
			DS_ROOT: if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = DS_IDLE;
			default: state_d = DS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == DS_ROOT) && (cnt_q == CNT_W'(ROOT_STEPS - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DS_IDLE && req.start) begin
			ax_q <= abs_x[COORD_W-1:0];
			ay_q <= abs_y[COORD_W-1:0];
		end
		if (state_q == DS_SQX || state_q == DS_SQY) begin
			prod_q <= mul_in * mul_in;
		end
		if (state_q == DS_SQY) begin
			rad_q <= RAD_W'(prod_q);
		end
		if (state_q == DS_SUM) begin
			rad_q  <= rad_q + RAD_W'(prod_q);
			rem_q  <= '0;
			root_q <= '0;
			cnt_q  <= '0;
		end
		if (state_q == DS_ROOT) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			cnt_q <= cnt_q + 1'b1;
			if (shifted >= trial) begin
				rem_q  <= REM_W'(shifted - trial);
				root_q <= {root_q[DIST_W-2:0], 1'b1};
			end else begin
				rem_q  <= REM_W'(shifted);
				root_q <= {root_q[DIST_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign dist_len = root_q;

endmodule

// ===== rtl/core/euclidean_mst_prim.sv =====
// Euclidean minimum spanning tree length, dense Prim. Points stream in on
// the slave side at one transaction per cycle, x in tdata[23:0] and y in
// tdata[47:24], signed fixed point (Q16.8 by default; lengths keep the same
// scale), tlast on the final point of a set. Up to MAX_POINTS points are
// kept; later ones are dropped and flagged. After tlast the block stops
// accepting and runs Prim from point 0, ties to the lowest index. Every
// edge length floor(sqrt(dx^2+dy^2)) is recomputed on demand by one shared
// distance unit (one multiplier used twice, then a 25-step square root).
// One result transaction follows; the block then takes a new set. Point and
// best-distance tables sit in single-port-read RAMs; the best-distance table
// is initialized during Prim's first round, so no clearing pass is needed
// after reset.
module euclidean_mst_prim
	import emp_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // coord_x[23:0], coord_y[47:24]
	input  logic        s_tlast,   // last_point
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // total_length[30:0], point_count[37:31],
	                               // overflow[38], zero pad[39]
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int BW = DIST_W + 1;   // {in_tree, best distance}

	emp_state_t state_q, state_d;

	logic [CW-1:0]        cnt_q;
	logic                 dropped_q;
	logic                 sat_q;
	logic [TOTAL_W-1:0]   total_q;
	logic [AW-1:0]        pick_q, idx_q, min_idx_q;
	logic [DIST_W-1:0]    min_q, old_best_q;
	logic                 found_q;
	logic                 first_q;
	logic [COORD_W-1:0]   px_q, py_q;

	// memory ports
	logic                 xy_we;
	logic [AW-1:0]        xy_raddr;
	logic [2*COORD_W-1:0] xy_rdata;
	logic                 bd_we;
	logic [AW-1:0]        bd_waddr;
	logic [BW-1:0]        bd_wdata;
	logic [BW-1:0]        bd_rdata;

	dist_req_t            dreq;
	dist_rsp_t            drsp;
	logic [DIST_W-1:0]    dist_len;
	logic signed [DIFF_W-1:0] dx, dy;

	logic                 s_acc, m_acc;
	logic                 idx_end;
	logic                 cur_in_tree;
	logic [DIST_W-1:0]    cur_best;
	logic [DIST_W-1:0]    new_best;
	logic [TOTAL_W:0]     sum;

	assign s_acc   = s_tvalid && s_tready;
	assign m_acc   = m_tvalid && m_tready;
	assign idx_end = (idx_q == AW'(cnt_q - 1'b1));

	// first round: table is not yet written, so treat all but point 0 as fresh
	assign cur_in_tree = first_q ? (idx_q == '0) : bd_rdata[BW-1];
	assign cur_best    = first_q ? DIST_INF : bd_rdata[DIST_W-1:0];
	assign new_best    = (dist_len < old_best_q) ? dist_len : old_best_q;
	assign sum         = {1'b0, total_q} + (TOTAL_W+1)'(min_q);

	assign dx = DIFF_W'($signed(px_q)) - DIFF_W'($signed(xy_rdata[COORD_W-1:0]));
	assign dy = DIFF_W'($signed(py_q)) - DIFF_W'($signed(xy_rdata[2*COORD_W-1:COORD_W]));

	emp_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_POINTS)) u_xy_ram (
		.clk   (clk),
		.we    (xy_we),
		.waddr (AW'(cnt_q)),
		.wdata (s_tdata),
		.raddr (xy_raddr),
		.rdata (xy_rdata)
	);

	emp_ram #(.WIDTH(BW), .DEPTH(MAX_POINTS)) u_best_ram (
		.clk   (clk),
		.we    (bd_we),
		.waddr (bd_waddr),
		.wdata (bd_wdata),
		.raddr (idx_q),
		.rdata (bd_rdata)
	);

	emp_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dreq),
		.dx       (dx),
		.dy       (dy),
		.rsp      (drsp),
		.dist_len (dist_len)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:    if (s_acc && s_tlast) state_d = ST_START;
			ST_START:   state_d = ST_PICK_RD;
			ST_PICK_RD: state_d = ST_PICK_WT;
			ST_PICK_WT: state_d = ST_SCAN_RD;
			ST_SCAN_RD: state_d = ST_SCAN_WT;
			ST_SCAN_WT: begin
				if (!cur_in_tree) state_d = ST_DIST;
				else if (idx_end) state_d = ST_NEXT;
				else              state_d = ST_SCAN_RD;
			end
			ST_DIST:    if (drsp.done) state_d = ST_UPD;
			ST_UPD:     state_d = idx_end ? ST_NEXT : ST_SCAN_RD;
			ST_NEXT:    state_d = found_q ? ST_PICK_RD : ST_OUT;
			ST_OUT:     if (m_acc) state_d = ST_LOAD;
			default:    state_d = ST_LOAD;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		s_tready   = 1'b0;
		m_tvalid   = 1'b0;
		xy_we      = 1'b0;
		xy_raddr   = idx_q;
		bd_we      = 1'b0;
		bd_waddr   = idx_q;
		bd_wdata   = {1'b0, new_best};
		dreq.start = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				xy_we    = s_tvalid && (cnt_q < CW'(MAX_POINTS));
			end
			ST_START: begin
				bd_we    = 1'b1;
				bd_waddr = '0;
				bd_wdata = {1'b1, DIST_W'(0)};
			end
			ST_PICK_RD: xy_raddr = pick_q;
			ST_SCAN_WT: dreq.start = !cur_in_tree;
			ST_UPD:     bd_we = 1'b1;
			ST_NEXT: begin
				bd_we    = found_q;
				bd_waddr = min_idx_q;
				bd_wdata = {1'b1, min_q};
			end
			ST_OUT:     m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			sat_q     <= 1'b0;
			total_q   <= '0;
			found_q   <= 1'b0;
			first_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (s_acc) begin
						if (cnt_q < CW'(MAX_POINTS)) cnt_q <= cnt_q + 1'b1;
						else                         dropped_q <= 1'b1;
					end
				end
				ST_START: begin
					first_q <= 1'b1;
					total_q <= '0;
					sat_q   <= 1'b0;
				end
				ST_PICK_WT: found_q <= 1'b0;
				ST_UPD: begin
					if (!found_q || new_best < min_q) found_q <= 1'b1;
				end
				ST_NEXT: begin
					first_q <= 1'b0;
					if (found_q) begin
						if (sum[TOTAL_W]) begin
							total_q <= TOTAL_MAX;
							sat_q   <= 1'b1;
						end else begin
							total_q <= sum[TOTAL_W-1:0];
						end
					end
				end
				ST_OUT: begin
					if (m_acc) begin
						cnt_q     <= '0;
						dropped_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_START:   pick_q <= '0;
			ST_PICK_WT: begin
				px_q  <= xy_rdata[COORD_W-1:0];
				py_q  <= xy_rdata[2*COORD_W-1:COORD_W];
				idx_q <= '0;
			end
			ST_SCAN_WT: begin
				old_best_q <= cur_best;
				if (cur_in_tree && !idx_end) idx_q <= idx_q + 1'b1;
			end
			ST_UPD: begin
				if (!found_q || new_best < min_q) begin
					min_q     <= new_best;
					min_idx_q <= idx_q;
				end
				if (!idx_end) idx_q <= idx_q + 1'b1;
			end
			ST_NEXT:    pick_q <= min_idx_q;
			default: ;
		endcase
	end

	assign m_tdata = {1'b0, dropped_q || sat_q, COUNT_W'(cnt_q), total_q};

endmodule

// ===== rtl/core/emp_checker.sv =====
module emp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while result pending");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("ready after last point");

	a_result_then_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> (s_tready && !m_tvalid))
		else $error("not ready after result transaction");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

bind euclidean_mst_prim emp_checker u_emp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/euclidean_mst_prim_tb.sv =====
`timescale 1ns / 100ps

module euclidean_mst_prim_tb
	import emp_pkg::*;
();

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int WATCHDOG_LIMIT = 400000;

	typedef struct {
		logic [30:0] total_length;
		logic [6:0]  point_count;
		logic        overflow;
	} tree_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;    // coord_x[23:0], coord_y[47:24]
	logic        s_tlast;    // last_point
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // total_length[30:0], point_count[37:31], overflow[38]

	// predictor copy of the point set
	logic signed [23:0] set_x [NPTS];
	logic signed [23:0] set_y [NPTS];
	int                 set_count;
	bit                 set_dropped;

	tree_result_t expected_trees [$];
	int  mismatches;
	int  trees_checked;
	int  points_sent;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  idle_cycles;

	euclidean_mst_prim uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// floor(sqrt(v)) by the digit-pair method
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned rem, root, b;
		rem = v;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function automatic longint unsigned edge_length(int a, int b);
		longint dx, dy;
		longint unsigned ax, ay;
		dx = longint'(set_x[a]) - longint'(set_x[b]);
		dy = longint'(set_y[a]) - longint'(set_y[b]);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		return int_sqrt(ax * ax + ay * ay);
	endfunction

	// dense Prim from point 0, lowest index wins ties
	function automatic tree_result_t span_tree();
		longint unsigned best [NPTS];
		bit              joined [NPTS];
		longint unsigned total, d;
		bit              sat;
		int              pick;
		tree_result_t    r;
		total = 0;
		sat = 0;
		for (int i = 0; i < NPTS; i++) begin
			best[i] = 64'h1FFFFFF;
			joined[i] = 0;
		end
		best[0] = 0;
		for (int rnd = 0; rnd < set_count; rnd++) begin
			pick = set_count;
			for (int i = 0; i < set_count; i++)
				if (!joined[i] && (pick == set_count || best[i] < best[pick]))
					pick = i;
			if (pick >= set_count) break;
			joined[pick] = 1;
			total += best[pick];
			if (total > 64'h7FFFFFFF) begin
				total = 64'h7FFFFFFF;
				sat = 1;
			end
			for (int i = 0; i < set_count; i++)
				if (!joined[i]) begin
					d = edge_length(pick, i);
					if (d < best[i]) best[i] = d;
				end
		end
		r.total_length = total[30:0];
		r.point_count = set_count[6:0];
		r.overflow = set_dropped | sat;
		return r;
	endfunction

	// one point transaction; the model is updated on acceptance.
	// tvalid stays up afterwards; wait_drained, or an idle gap in the next call, lowers it.
	task automatic send_point(logic [23:0] x, logic [23:0] y, bit last);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {y, x};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		points_sent++;
		if (set_count < NPTS) begin
			set_x[set_count] = x;
			set_y[set_count] = y;
			set_count++;
		end else begin
			set_dropped = 1;
		end
		if (last) begin
			expected_trees.push_back(span_tree());
			set_count = 0;
			set_dropped = 0;
		end
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_trees.size() != 0) @(posedge clk);
	endtask

	task automatic send_set(int n, int span);
		for (int i = 0; i < n; i++)
			send_point(24'($urandom_range(2 * span) - span),
				24'($urandom_range(2 * span) - span), i == n - 1);
	endtask

	task automatic test_directed();
		// single point, then opposite-corner extremes
		send_point(24'h000000, 24'h000000, 1);
		send_point(24'h800000, 24'h800000, 0);
		send_point(24'h7FFFFF, 24'h7FFFFF, 1);
		send_point(24'h7FFFFF, 24'h800000, 0);
		send_point(24'h800000, 24'h7FFFFF, 0);
		send_point(24'hFFFFFF, 24'h000001, 1);
		// duplicates contribute zero
		send_point(24'h001234, 24'hFFEDCB, 0);
		send_point(24'h001234, 24'hFFEDCB, 0);
		send_point(24'h001235, 24'hFFEDCB, 1);
		// equal distances check tie order
		send_point(24'h0, 24'h0, 0);
		send_point(24'h100, 24'h0, 0);
		send_point(24'hFFFF00, 24'h0, 0);
		send_point(24'h0, 24'h100, 1);
		wait_drained();
	endtask

	// corners repeat so long edges mix with duplicates, and points past the store drop
	task automatic test_store_drop();
		for (int i = 0; i < NPTS + 3; i++)
			send_point(i[0] ? 24'h7FFFFF : 24'h800000, i[1] ? 24'h7FFFFF : 24'h800000,
				i == NPTS + 2);
		wait_drained();
	endtask

	// random sets, mostly small; the odd large one
	task automatic test_random(int points);
		int n, sent, span;
		sent = 0;
		while (sent < points) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(NPTS - 8, NPTS + 2)
				: $urandom_range(1, 8);
			span = ($urandom_range(3) == 0) ? 8388607 : (1 << $urandom_range(4, 20));
			send_set(n, span);
			sent += n;
		end
	endtask

	// receiver with random backpressure, field-wise compare
	always @(posedge clk) begin
		tree_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_trees.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = expected_trees.pop_front();
					trees_checked++;
					if (m_tdata[30:0] !== want.total_length || m_tdata[37:31] !== want.point_count
						|| m_tdata[38] !== want.overflow) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: exp len=%0d cnt=%0d ovf=%0d got len=%0d cnt=%0d ovf=%0d",
								trees_checked, want.total_length, want.point_count, want.overflow,
								m_tdata[30:0], m_tdata[37:31], m_tdata[38]);
					end
				end
			end
			m_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		points_sent = 0;
		set_count = 0;
		set_dropped = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_store_drop();
		send_idle_pct = 12;
		recv_idle_pct = 62;
		test_random(110);
		wait_drained();
		send_idle_pct = 62;
		recv_idle_pct = 12;
		test_random(110);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(110);

		wait_drained();
		repeat (50) @(posedge clk);
		$display("Covered %0d points in %0d spanning trees: extremes, duplicates, ties,",
			points_sent, trees_checked);
		$display("store overflow and random sets under backpressure.");
		if (mismatches == 0 && expected_trees.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
